[rtl/u8ds_pkg.sv]
// ----------------------------------------------------------------------------
// u8ds_pkg
// Shared types, constants and the code point to letter map for the UTF-8
// diacritic stripper.
// ----------------------------------------------------------------------------
`default_nettype none

package u8ds_pkg;

  localparam logic [6:0] CHAR_QMARK = 7'h3F;

  // Result of one examination of the front of the pending buffer
  typedef enum logic [2:0] {
    ACT_EMIT_ASCII, // pass front byte, drop 1
    ACT_DROP_ONE,   // stray continuation, invalid byte or bad continuation: drop 1
    ACT_EMIT_CP,    // full sequence: map and drop len
    ACT_WAIT,       // sequence incomplete
    ACT_EMPTY       // nothing buffered
  } act_t;

  typedef struct packed {
    act_t       act;
    logic [2:0] drop_n;
    logic [6:0] ch;
  } dec_res_t;

  // Lead byte length; 0 for non-lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] l;
    l = 3'd0;
    if (b[7:5] == 3'b110) l = 3'd2;
    else if (b[7:4] == 4'b1110) l = 3'd3;
    else if (b[7:3] == 5'b11110) l = 3'd4;
    return l;
  endfunction

  // Map a code point to its base ASCII letter or '?'
  function automatic logic [6:0] map_letter(input logic [20:0] cp);
    logic [6:0] c;
    logic       odd;
    c   = CHAR_QMARK;
    odd = cp[0];
    unique case (cp)
      21'h0E0, 21'h0E1, 21'h0E2, 21'h0E3, 21'h103: c = 7'h61;
      21'h0C0, 21'h0C1, 21'h0C2, 21'h0C3, 21'h102: c = 7'h41;
      21'h0E8, 21'h0E9, 21'h0EA: c = 7'h65;
      21'h0C8, 21'h0C9, 21'h0CA: c = 7'h45;
      21'h0EC, 21'h0ED: c = 7'h69;
      21'h0CC, 21'h0CD: c = 7'h49;
      21'h0F2, 21'h0F3, 21'h0F4, 21'h0F5, 21'h1A1: c = 7'h6F;
      21'h0D2, 21'h0D3, 21'h0D4, 21'h0D5, 21'h1A0: c = 7'h4F;
      21'h0F9, 21'h0FA, 21'h1B0: c = 7'h75;
      21'h0D9, 21'h0DA, 21'h1AF: c = 7'h55;
      21'h0FD: c = 7'h79;
      21'h0DD: c = 7'h59;
      21'h111: c = 7'h64;
      21'h110: c = 7'h44;
      default: begin
        if (cp >= 21'h1EA0 && cp <= 21'h1EB7) c = odd ? 7'h61 : 7'h41;
        else if (cp >= 21'h1EB8 && cp <= 21'h1EC7) c = odd ? 7'h65 : 7'h45;
        else if (cp >= 21'h1EC8 && cp <= 21'h1ECB) c = odd ? 7'h69 : 7'h49;
        else if (cp >= 21'h1ECC && cp <= 21'h1EE3) c = odd ? 7'h6F : 7'h4F;
        else if (cp >= 21'h1EE4 && cp <= 21'h1EF1) c = odd ? 7'h75 : 7'h55;
        else if (cp >= 21'h1EF2 && cp <= 21'h1EF9) c = odd ? 7'h79 : 7'h59;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/u8ds_decode.sv]
// ----------------------------------------------------------------------------
// u8ds_decode
// Decode unit: examines the front of the pending buffer once and
// reports what to do with it.
// ----------------------------------------------------------------------------
`default_nettype none

module u8ds_decode (
  input  wire logic [31:0]         buf_i,   // byte 0 in [7:0]
  input  wire logic [2:0]          count_i,
  output u8ds_pkg::dec_res_t       res_o
);

  logic [7:0]  b0, b1, b2, b3;
  logic [2:0]  len;
  logic        ok;
  logic [20:0] cp;

  // Decode the front sequence
  always_comb begin
    b0  = buf_i[7:0];
    b1  = buf_i[15:8];
    b2  = buf_i[23:16];
    b3  = buf_i[31:24];
    len = u8ds_pkg::lead_len(b0);
    ok  = 1'b1;
    cp  = '0;
    unique case (len)
      3'd2: begin
        ok = (b1[7:6] == 2'b10);
        cp = {10'd0, b0[4:0], b1[5:0]};
      end
      3'd3: begin
        ok = (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10);
        cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      end
      3'd4: begin
        ok = (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10) && (b3[7:6] == 2'b10);
        cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      end
      default: begin
        ok = 1'b0;
        cp = '0;
      end
    endcase

    res_o.ch     = b0[6:0];
    res_o.drop_n = 3'd1;
    if (count_i == 3'd0) begin
      res_o.act = u8ds_pkg::ACT_EMPTY;
    end else if (!b0[7]) begin
      res_o.act = u8ds_pkg::ACT_EMIT_ASCII;
    end else if (len == 3'd0) begin
      res_o.act = u8ds_pkg::ACT_DROP_ONE;
    end else if (count_i < len) begin
      res_o.act = u8ds_pkg::ACT_WAIT;
    end else if (!ok) begin
      res_o.act = u8ds_pkg::ACT_DROP_ONE;
    end else begin
      res_o.act    = u8ds_pkg::ACT_EMIT_CP;
      res_o.drop_n = len;
      res_o.ch     = u8ds_pkg::map_letter(cp);
    end
  end

endmodule

`default_nettype wire

[rtl/utf8_diacritic_strip_to_ascii_core.sv]
// ----------------------------------------------------------------------------
// utf8_diacritic_strip_to_ascii_core
// UTF-8 to ASCII stripper: buffers multi-byte sequences and emits base letters.
// ----------------------------------------------------------------------------
// Operation: a byte is taken in S_IDLE, then the decode unit examines the
// pending buffer once per S_RUN pass; a found character is held until the
// next one is found or the step ends, so the final word of a string can
// carry last. Each output word waits in S_OUT for out_tready. A step is a run of
// decode passes over up to 4 buffered bytes plus up to 3 output handshakes;
// in_tready is low for the whole step, so no new byte is taken until it ends.
// Reset: synchronous active-low rst_n empties the buffer and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_diacritic_strip_to_ascii_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tlast,   // end_of_string
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [6:0] ascii_char, [7] zero
  output logic            out_tuser,  // char_valid
  output logic            out_tlast   // last_result
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;

  state_t      state_r;
  logic [31:0] buf_r;
  logic [2:0]  cnt_r;
  logic        end_r;
  logic        held_r;
  logic [6:0]  hch_r;
  logic        done_r;
  logic [6:0]  och_r;
  logic        ovalid_r;
  logic        olast_r;
  logic        ov_r;

  u8ds_pkg::dec_res_t dres;

  u8ds_decode u_dec (
    .buf_i   (buf_r),
    .count_i (cnt_r),
    .res_o   (dres)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, och_r};
  assign out_tuser  = ovalid_r;
  assign out_tlast  = olast_r;

  // Sequencer: load, step the decoder, hand out one word at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      buf_r    <= 32'd0;
      cnt_r    <= 3'd0;
      ov_r     <= 1'b0;
      end_r    <= 1'b0;
      held_r   <= 1'b0;
      hch_r    <= 7'd0;
      done_r   <= 1'b0;
      och_r    <= 7'd0;
      ovalid_r <= 1'b0;
      olast_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            if (cnt_r < 3'd4) begin
              buf_r[cnt_r[1:0]*8 +: 8] <= in_tdata;
              cnt_r <= cnt_r + 3'd1;
            end
            end_r   <= in_tlast;
            held_r  <= 1'b0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          unique case (dres.act)
            u8ds_pkg::ACT_EMIT_ASCII, u8ds_pkg::ACT_EMIT_CP: begin
              buf_r  <= buf_r >> (dres.drop_n * 8);
              cnt_r  <= cnt_r - dres.drop_n;
              hch_r  <= dres.ch;
              held_r <= 1'b1;
              // a newer character follows, so the held one is not last
              if (held_r) begin
                och_r    <= hch_r;
                ovalid_r <= 1'b1;
                olast_r  <= 1'b0;
                done_r   <= 1'b0;
                ov_r     <= 1'b1;
                state_r  <= S_OUT;
              end
            end
            u8ds_pkg::ACT_DROP_ONE: begin
              buf_r <= buf_r >> 8;
              cnt_r <= cnt_r - 3'd1;
            end
            default: begin
              // wait or empty: flush the held character and end the step
              if (dres.act == u8ds_pkg::ACT_WAIT && end_r) cnt_r <= 3'd0;
              held_r <= 1'b0;
              done_r <= 1'b1;
              if (end_r) begin
                och_r    <= held_r ? hch_r : 7'd0;
                ovalid_r <= held_r;
                olast_r  <= 1'b1;
                ov_r     <= 1'b1;
                state_r  <= S_OUT;
              end else if (held_r) begin
                och_r    <= hch_r;
                ovalid_r <= 1'b1;
                olast_r  <= 1'b0;
                ov_r     <= 1'b1;
                state_r  <= S_OUT;
              end else begin
                state_r <= S_IDLE;
              end
            end
          endcase
        end
        S_OUT: begin
          if (out_tready) begin
            ov_r    <= 1'b0;
            state_r <= done_r ? S_IDLE : S_RUN;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Pending count never exceeds four bytes
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("pending count overflow");
  // Output only presented while in the output state
  assert property (@(posedge clk) disable iff (!rst_n) ov_r |-> state_r == S_OUT)
    else $error("output valid outside output state");
  // An accepted input word starts a run
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == S_RUN)
    else $error("accepted word did not start a run");

endmodule

`default_nettype wire

[dv/u8ds_checker.sv]
// ----------------------------------------------------------------------------
// u8ds_checker
// Watches both streams of the UTF-8 stripper, predicts the ASCII words from
// each accepted input byte and compares them in order with the output words.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module u8ds_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic       in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  input  wire logic       out_tvalid,
  input  wire logic       out_tready,
  input  wire logic [7:0] out_tdata,
  input  wire logic       out_tuser,
  input  wire logic       out_tlast,
  output int              fail_count,
  output int              pending_words
);

  typedef struct packed {
    logic       last;
    logic       valid;
    logic [6:0] ch;
  } ascii_word_t;

  ascii_word_t expected_words[$];
  logic [7:0]  held_bytes[4];
  int          held_count;

  assign pending_words = expected_words.size();

  function automatic int seq_len(logic [7:0] b);
    if (b[7:5] == 3'b110) return 2;
    if (b[7:4] == 4'b1110) return 3;
    if (b[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  function automatic logic [7:0] base_letter(logic [20:0] cp);
    logic odd;
    odd = cp[0];
    case (cp)
      'h0E0, 'h0E1, 'h0E2, 'h0E3, 'h103: return "a";
      'h0C0, 'h0C1, 'h0C2, 'h0C3, 'h102: return "A";
      'h0E8, 'h0E9, 'h0EA: return "e";
      'h0C8, 'h0C9, 'h0CA: return "E";
      'h0EC, 'h0ED: return "i";
      'h0CC, 'h0CD: return "I";
      'h0F2, 'h0F3, 'h0F4, 'h0F5, 'h1A1: return "o";
      'h0D2, 'h0D3, 'h0D4, 'h0D5, 'h1A0: return "O";
      'h0F9, 'h0FA, 'h1B0: return "u";
      'h0D9, 'h0DA, 'h1AF: return "U";
      'h0FD: return "y";
      'h0DD: return "Y";
      'h111: return "d";
      'h110: return "D";
      default: ;
    endcase
    if (cp >= 'h1EA0 && cp <= 'h1EB7) return odd ? "a" : "A";
    if (cp >= 'h1EB8 && cp <= 'h1EC7) return odd ? "e" : "E";
    if (cp >= 'h1EC8 && cp <= 'h1ECB) return odd ? "i" : "I";
    if (cp >= 'h1ECC && cp <= 'h1EE3) return odd ? "o" : "O";
    if (cp >= 'h1EE4 && cp <= 'h1EF1) return odd ? "u" : "U";
    if (cp >= 'h1EF2 && cp <= 'h1EF9) return odd ? "y" : "Y";
    return "?";
  endfunction

  function automatic void shift_out(int n);
    for (int k = 0; k + n < held_count; k++) held_bytes[k] = held_bytes[k + n];
    held_count -= n;
  endfunction

  // Decode one byte against the held sequence and queue the ASCII words
  task automatic strip_byte(logic [7:0] b, logic eos);
    int          len;
    int          produced;
    logic        good;
    logic [20:0] cp;
    logic [7:0]  ch8;
    ascii_word_t w;
    produced = 0;
    if (held_count < 4) begin
      held_bytes[held_count] = b;
      held_count++;
    end
    while (held_count > 0) begin
      if (held_bytes[0] < 8'h80) begin
        w = '{1'b0, 1'b1, held_bytes[0][6:0]};
        expected_words.push_back(w);
        produced++;
        shift_out(1);
        continue;
      end
      len = seq_len(held_bytes[0]);
      if (len == 0) begin
        shift_out(1);
        continue;
      end
      if (held_count < len) begin
        if (eos) held_count = 0;
        break;
      end
      cp = (len == 2) ? {16'd0, held_bytes[0][4:0]} :
           (len == 3) ? {17'd0, held_bytes[0][3:0]} : {18'd0, held_bytes[0][2:0]};
      good = 1'b1;
      for (int k = 1; k < len; k++) begin
        if (held_bytes[k][7:6] != 2'b10) good = 1'b0;
        else if (good) cp = {cp[14:0], held_bytes[k][5:0]};
      end
      if (!good) begin
        shift_out(1);
        continue;
      end
      ch8 = base_letter(cp);
      w = '{1'b0, 1'b1, ch8[6:0]};
      expected_words.push_back(w);
      produced++;
      shift_out(len);
    end
    if (eos) begin
      if (produced == 0) expected_words.push_back('{1'b0, 1'b0, 7'd0});
      expected_words[$].last = 1'b1;
    end
  endtask

  // Predict on accepted input words, compare on accepted output words
  always @(posedge clk) begin
    ascii_word_t got;
    ascii_word_t want;
    if (!rst_n) begin
      held_count = 0;
      fail_count = 0;
      expected_words.delete();
    end else begin
      if (in_tvalid && in_tready) strip_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got = '{out_tlast, out_tuser, out_tdata[6:0]};
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected word %h last %b", out_tdata, out_tlast);
        end else begin
          want = expected_words.pop_front();
          if (got !== want || out_tdata[7] !== 1'b0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected ch %h valid %b last %b, got data %h valid %b last %b",
                       want.ch, want.valid, want.last, out_tdata, got.valid, got.last);
          end
        end
      end
    end
  end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives UTF-8 strings into the stripper: directed corner cases, then random
// strings of mostly well-formed sequences, under several idling phases and
// one long output hold-off. The checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;
  int         fail_count;
  int         pending_words;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  utf8_diacritic_strip_to_ascii_core DUT (.*);

  u8ds_checker checker_i (.*);

  // Output ready: random stalls, or a counted hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one word, idling first at random, and wait until it is taken
  task automatic send_word(logic [7:0] b, logic eos);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Send a well-formed sequence carrying a code point
  task automatic send_cp(logic [20:0] cp, int len, logic eos);
    case (len)
      1: send_word({1'b0, cp[6:0]}, eos);
      2: begin
        send_word({3'b110, cp[10:6]}, 1'b0);
        send_word({2'b10, cp[5:0]}, eos);
      end
      3: begin
        send_word({4'b1110, cp[15:12]}, 1'b0);
        send_word({2'b10, cp[11:6]}, 1'b0);
        send_word({2'b10, cp[5:0]}, eos);
      end
      default: begin
        send_word({5'b11110, cp[20:18]}, 1'b0);
        send_word({2'b10, cp[17:12]}, 1'b0);
        send_word({2'b10, cp[11:6]}, 1'b0);
        send_word({2'b10, cp[5:0]}, eos);
      end
    endcase
  endtask

  task automatic send_random_string();
    int          n;
    int          pick;
    logic [20:0] cp;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 25) send_cp(21'($urandom_range(0, 127)), 1, i == n - 1);
      else if (pick < 50) send_cp(21'($urandom_range('hC0, 'h1B0)), 2, i == n - 1);
      else if (pick < 70) send_cp(21'($urandom_range('h1E9C, 'h1EFC)), 3, i == n - 1);
      else if (pick < 78) begin
        cp = 21'($urandom);
        send_cp(cp, $urandom_range(2, 4), i == n - 1);
      end else send_word(8'($urandom), i == n - 1);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: pass-through extremes, mapped letters, stray continuation and
    // invalid bytes, bad continuation, truncation at end, empty end marker, overlong form
    send_word(8'h00, 1'b0);
    send_word(8'h7F, 1'b0);
    send_cp('h0E0, 2, 1'b0);
    send_cp('h1EA1, 3, 1'b0);
    send_cp('h1F600, 4, 1'b1);
    send_word(8'h80, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hF8, 1'b1);
    send_word(8'hE1, 1'b0);
    send_word(8'h41, 1'b0);
    send_word(8'hBA, 1'b0);
    send_word(8'hC3, 1'b1);
    send_word(8'h42, 1'b0);
    send_word(8'hF0, 1'b0);
    send_word(8'h9F, 1'b1);
    send_word(8'hC0, 1'b0);
    send_word(8'hAA, 1'b1);
    send_cp('h110, 2, 1'b1);
    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 87 : (ph == 3) ? 19 : 0;
      recv_stall_pct = (ph == 2) ? 87 : (ph == 3) ? 19 : 0;
      if (ph == 0) hold_cycles <= 60;
      repeat (8) send_random_string();
    end
    in_tvalid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_words != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
